// File: rtl/hic_pkg.sv
package hic_pkg;

    // Grid side is 2**GRID_BITS cells; default of the top-level parameter.
    localparam int unsigned GRID_BITS_DEF = 10;

    // Width of the curve variant register.
    localparam int unsigned VARIANT_W = 4;

    // Curve variant codes. Codes outside this list act as the identity.
    typedef enum logic [VARIANT_W-1:0] {
        VAR_IDENT   = 4'd1,
        VAR_ROT180  = 4'd2,
        VAR_ROT90A  = 4'd3,
        VAR_ROT90B  = 4'd4,
        VAR_DIAG_PP = 4'd5,
        VAR_DIAG_MP = 4'd6,
        VAR_DIAG_PM = 4'd7,
        VAR_DIAG_MM = 4'd8
    } t_variant;

endpackage

// File: rtl/hic_xform.sv
module hic_xform #(
    parameter int unsigned GRID_BITS = hic_pkg::GRID_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [hic_pkg::VARIANT_W-1:0] i_variant,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [GRID_BITS-1:0]         i_x,
    input  logic [GRID_BITS-1:0]         i_y,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [GRID_BITS-1:0]         o_x,
    output logic [GRID_BITS-1:0]         o_y
);
    import hic_pkg::*;

    logic                 r_valid;
    logic [GRID_BITS-1:0] r_x;
    logic [GRID_BITS-1:0] r_y;
    logic [GRID_BITS-1:0] n_x;
    logic [GRID_BITS-1:0] n_y;
    logic                 x_lo_ok;
    logic                 x_hi_ok;
    logic                 y_lo_ok;
    logic                 y_hi_ok;

    // Edge tests for the diagonal shifts: the shifted cell must stay on the grid.
    assign x_hi_ok = (i_x != '1);
    assign x_lo_ok = (i_x != '0);
    assign y_hi_ok = (i_y != '1);
    assign y_lo_ok = (i_y != '0);

    // Variant transform. The complement of a coordinate is the edge value minus it.
    always_comb begin
        n_x = i_x;
        n_y = i_y;
        case (i_variant)
            VAR_ROT180: begin
                n_x = ~i_x;
                n_y = ~i_y;
            end
            VAR_ROT90A: begin
                n_x = ~i_y;
                n_y = i_x;
            end
            VAR_ROT90B: begin
                n_x = i_y;
                n_y = ~i_x;
            end
            VAR_DIAG_PP: begin
                if (x_hi_ok && y_hi_ok) begin
                    n_x = i_x + 1'b1;
                    n_y = i_y + 1'b1;
                end
            end
            VAR_DIAG_MP: begin
                if (x_lo_ok && y_hi_ok) begin
                    n_x = i_x - 1'b1;
                    n_y = i_y + 1'b1;
                end
            end
            VAR_DIAG_PM: begin
                if (x_hi_ok && y_lo_ok) begin
                    n_x = i_x + 1'b1;
                    n_y = i_y - 1'b1;
                end
            end
            VAR_DIAG_MM: begin
                if (x_lo_ok && y_lo_ok) begin
                    n_x = i_x - 1'b1;
                    n_y = i_y - 1'b1;
                end
            end
            default: begin
                n_x = i_x;
                n_y = i_y;
            end
        endcase
    end

    // The stage takes a new transfer whenever it is empty or its contents move on.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;

endmodule

// File: rtl/hic_cell.sv
module hic_cell #(
    parameter int unsigned GRID_BITS = hic_pkg::GRID_BITS_DEF,
    parameter int unsigned LEVEL     = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [GRID_BITS-1:0]     i_x,
    input  logic [GRID_BITS-1:0]     i_y,
    input  logic [2*GRID_BITS-1:0]   i_d,
    input  logic [GRID_BITS-1:0]     i_mx,
    input  logic [GRID_BITS-1:0]     i_my,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [GRID_BITS-1:0]     o_x,
    output logic [GRID_BITS-1:0]     o_y,
    output logic [2*GRID_BITS-1:0]   o_d,
    output logic [GRID_BITS-1:0]     o_mx,
    output logic [GRID_BITS-1:0]     o_my
);
    import hic_pkg::*;

    // Bits below this level stay in play for the following cells.
    localparam logic [GRID_BITS-1:0] LowMask = GRID_BITS'((1 << LEVEL) - 1);

    logic                   r_valid;
    logic [GRID_BITS-1:0]   r_x;
    logic [GRID_BITS-1:0]   r_y;
    logic [2*GRID_BITS-1:0] r_d;
    logic [GRID_BITS-1:0]   r_mx;
    logic [GRID_BITS-1:0]   r_my;
    logic [GRID_BITS-1:0]   n_x;
    logic [GRID_BITS-1:0]   n_y;
    logic [2*GRID_BITS-1:0] n_d;
    logic                   rx;
    logic                   ry;
    logic [GRID_BITS-1:0]   xm;
    logic [GRID_BITS-1:0]   ym;

    assign rx = i_x[LEVEL];
    assign ry = i_y[LEVEL];

    // One rotate-and-reflect step. The quadrant digit is (3*rx)^ry, which is {rx, rx^ry};
    // the lower index bits are still zero here, so it is placed rather than added.
    always_comb begin
        xm = i_x & LowMask;
        ym = i_y & LowMask;
        if (rx && !ry) begin
            xm = xm ^ LowMask;
            ym = ym ^ LowMask;
        end
        if (!ry) begin
            n_x = ym;
            n_y = xm;
        end else begin
            n_x = xm;
            n_y = ym;
        end
        n_d = i_d;
        n_d[2*LEVEL +: 2] = {rx, rx ^ ry};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_d  <= n_d;
            r_mx <= i_mx;
            r_my <= i_my;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_d     = r_d;
    assign o_mx    = r_mx;
    assign o_my    = r_my;

endmodule

// File: rtl/hilbert_index_with_curve_variant.sv
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+---------------------------------------
// config    | in        | i_cfg_valid / o_cfg_ready  | i_curve_variant
// cell in   | in        | i_valid / o_ready          | i_cell_x, i_cell_y
// result    | out       | o_valid / i_ready          | o_curve_index, o_mapped_x, o_mapped_y
//
// One item per cycle sustained while the result side is ready; the pipe has
// one variant transform stage, then one cell per coordinate bit, top bit first.
// The last cell's register is the output register.
// Each stage stalls only when it is full and the stage after it cannot take its
// contents, so bubbles close up during a stall on the result side.
// Synchronous active-low reset empties every stage and sets the variant to identity.
// The config port is always ready; writes are expected only while the pipe is empty.
module hilbert_index_with_curve_variant #(
    parameter int unsigned GRID_BITS = hic_pkg::GRID_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hic_pkg::VARIANT_W-1:0] i_curve_variant,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [GRID_BITS-1:0]          i_cell_x,
    input  logic [GRID_BITS-1:0]          i_cell_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2*GRID_BITS-1:0]        o_curve_index,
    output logic [GRID_BITS-1:0]          o_mapped_x,
    output logic [GRID_BITS-1:0]          o_mapped_y
);
    import hic_pkg::*;

    logic [VARIANT_W-1:0]   r_curve_variant;

    // Entry k is the output of cell k-1's register; entry 0 is the transform stage's output.
    logic                   s_valid [0:GRID_BITS];
    logic                   s_ready [0:GRID_BITS];
    logic [GRID_BITS-1:0]   s_x     [0:GRID_BITS];
    logic [GRID_BITS-1:0]   s_y     [0:GRID_BITS];
    logic [2*GRID_BITS-1:0] s_d     [0:GRID_BITS];
    logic [GRID_BITS-1:0]   s_mx    [0:GRID_BITS];
    logic [GRID_BITS-1:0]   s_my    [0:GRID_BITS];

    // Configuration register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_variant <= VAR_IDENT;
        end else if (i_cfg_valid) begin
            r_curve_variant <= i_curve_variant;
        end
    end

    // Variant transform stage.
    hic_xform #(
        .GRID_BITS (GRID_BITS)
    ) u_xform (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_variant (r_curve_variant),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_x       (i_cell_x),
        .i_y       (i_cell_y),
        .o_valid   (s_valid[0]),
        .i_ready   (s_ready[0]),
        .o_x       (s_x[0]),
        .o_y       (s_y[0])
    );

    // The moved cell rides along the chain unchanged; the index starts at zero.
    assign s_mx[0] = s_x[0];
    assign s_my[0] = s_y[0];
    assign s_d[0]  = '0;

    // Chain of cells, one per coordinate bit, top bit first.
    for (genvar j = 0; j < GRID_BITS; j++) begin : g_cell
        hic_cell #(
            .GRID_BITS (GRID_BITS),
            .LEVEL     (GRID_BITS - 1 - j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[j]),
            .o_ready (s_ready[j]),
            .i_x     (s_x[j]),
            .i_y     (s_y[j]),
            .i_d     (s_d[j]),
            .i_mx    (s_mx[j]),
            .i_my    (s_my[j]),
            .o_valid (s_valid[j+1]),
            .i_ready (s_ready[j+1]),
            .o_x     (s_x[j+1]),
            .o_y     (s_y[j+1]),
            .o_d     (s_d[j+1]),
            .o_mx    (s_mx[j+1]),
            .o_my    (s_my[j+1])
        );
    end

    // Result channel from the last cell.
    assign s_ready[GRID_BITS] = i_ready;
    assign o_valid            = s_valid[GRID_BITS];
    assign o_curve_index      = s_d[GRID_BITS];
    assign o_mapped_x         = s_mx[GRID_BITS];
    assign o_mapped_y         = s_my[GRID_BITS];

endmodule

// File: rtl/hic_checker.sv
module hic_checker #(
    parameter int unsigned GRID_BITS = hic_pkg::GRID_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [hic_pkg::VARIANT_W-1:0] i_curve_variant,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic [GRID_BITS-1:0]          i_cell_x,
    input logic [GRID_BITS-1:0]          i_cell_y,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [2*GRID_BITS-1:0]        o_curve_index,
    input logic [GRID_BITS-1:0]          o_mapped_x,
    input logic [GRID_BITS-1:0]          o_mapped_y
);
    import hic_pkg::*;

    // A result that was not taken stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_curve_index)
            && $stable(o_mapped_x) && $stable(o_mapped_y))
        else $error("result changed while stalled");

    // Reset leaves no result on the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // The top quadrant digit of the index follows from the top bits of the mapped cell.
    a_top_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_curve_index[2*GRID_BITS-1] == o_mapped_x[GRID_BITS-1]
            && o_curve_index[2*GRID_BITS-2] == (o_mapped_x[GRID_BITS-1] ^ o_mapped_y[GRID_BITS-1]))
        else $error("top index digit disagrees with mapped cell");

    // The config port never stalls a write.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write stalled");

endmodule

bind hilbert_index_with_curve_variant hic_checker #(
    .GRID_BITS (GRID_BITS)
) u_hic_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cfg_valid     (i_cfg_valid),
    .o_cfg_ready     (o_cfg_ready),
    .i_curve_variant (i_curve_variant),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .i_cell_x        (i_cell_x),
    .i_cell_y        (i_cell_y),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_curve_index   (o_curve_index),
    .o_mapped_x      (o_mapped_x),
    .o_mapped_y      (o_mapped_y)
);
